FILE: src/plfb_pkg.sv
`default_nettype none
package plfb_pkg;

  localparam int CHANNELS = 8;
  localparam int CH_W     = 3;
  localparam int CNT_W    = 4;
  localparam int PCT_W    = 7;
  localparam int TIME_W   = 16;
  localparam int DUTY_W   = 16;
  localparam int STEP_W   = 17;
  localparam int UNIT_W   = 10;
  localparam int PWM_B_W  = 5;
  localparam int TICK_W   = 10;
  localparam int MEM_W    = 2 * DUTY_W + STEP_W;
  localparam int PCT_MAX  = 100;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] STATUS_DUTY    = 2'd0;
  localparam logic [1:0] STATUS_SET_OK  = 2'd1;
  localparam logic [1:0] STATUS_SET_REJ = 2'd2;

  localparam logic [1:0] REG_PWM_WIDTH   = 2'd0;
  localparam logic [1:0] REG_TICK_PERIOD = 2'd1;
  localparam logic [1:0] REG_ACTIVE      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJ,
    ST_SET_RD,
    ST_DIV_STEPS,
    ST_DIV_STEP,
    ST_SET_WR,
    ST_TICK_RD,
    ST_TICK_UPD
  } state_t;

  function automatic logic [DUTY_W-1:0] duty_full_scale(input logic [PWM_B_W-1:0] b);
    logic [PWM_B_W-1:0] bc;
    logic [DUTY_W:0]    full;
    bc = b;
    if (bc == '0) begin
      bc = PWM_B_W'(1);
    end
    if (bc > PWM_B_W'(DUTY_W)) begin
      bc = PWM_B_W'(DUTY_W);
    end
    full = ((DUTY_W+1)'(1) << bc) - (DUTY_W+1)'(1);
    return full[DUTY_W-1:0];
  endfunction

  // One percent of the PWM range, rounded down, for each clamped width.
  function automatic logic [UNIT_W-1:0] pct_unit(input logic [PWM_B_W-1:0] b);
    logic [UNIT_W-1:0] u;
    u = '0;
    if (b > PWM_B_W'(DUTY_W)) begin
      u = UNIT_W'(655);
    end else begin
      case (b)
        5'd7:    u = UNIT_W'(1);
        5'd8:    u = UNIT_W'(2);
        5'd9:    u = UNIT_W'(5);
        5'd10:   u = UNIT_W'(10);
        5'd11:   u = UNIT_W'(20);
        5'd12:   u = UNIT_W'(40);
        5'd13:   u = UNIT_W'(81);
        5'd14:   u = UNIT_W'(163);
        5'd15:   u = UNIT_W'(327);
        5'd16:   u = UNIT_W'(655);
        default: u = '0;
      endcase
    end
    return u;
  endfunction

endpackage
`default_nettype wire

FILE: src/pwm_led_fade_bank_unit.sv
// Bank of eight PWM channels that fade linearly toward a target duty. A set word
// (tuser 0) loads a channel's target and per-tick step and returns one word with
// the target or a rejection; the step comes from two passes of the shared
// restoring divider (steps from fade time and tick period, then step from
// distance and steps). A tick word (tuser 1) walks the active channels from 0
// and returns one duty word per channel, the last one flagged by tlast; each
// channel is read from the channel memory, then written back as its word goes out.
// Words are taken one at a time. Channel state sits in an 8-entry memory cleared
// at reset through per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module pwm_led_fade_bank_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // channel[2:0], intensity[9:3], fade_time_ms[25:10]
  input  wire logic [0:0]  in_tuser,   // opcode[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // out_channel[2:0], duty[18:3]
  output logic      [1:0]  out_tuser,  // status[1:0]
  output logic             out_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CH_W   = plfb_pkg::CH_W;
  localparam int DUTY_W = plfb_pkg::DUTY_W;
  localparam int STEP_W = plfb_pkg::STEP_W;
  localparam int MEM_W  = plfb_pkg::MEM_W;
  localparam int CNT_W  = plfb_pkg::CNT_W;
  localparam int TIME_W = plfb_pkg::TIME_W;
  localparam int CHANNELS_LOCAL = plfb_pkg::CHANNELS;

  // Configuration registers.
  logic [plfb_pkg::PWM_B_W-1:0] pwm_bits_r;
  logic [plfb_pkg::TICK_W-1:0]  tick_r;
  logic [CNT_W-1:0]             active_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_bits_r <= plfb_pkg::PWM_B_W'(8);
      tick_r     <= plfb_pkg::TICK_W'(1);
      active_r   <= CNT_W'(8);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        plfb_pkg::REG_PWM_WIDTH:   pwm_bits_r <= pwdata[plfb_pkg::PWM_B_W-1:0];
        plfb_pkg::REG_TICK_PERIOD: tick_r     <= pwdata[plfb_pkg::TICK_W-1:0];
        plfb_pkg::REG_ACTIVE:      active_r   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      plfb_pkg::REG_PWM_WIDTH:   prdata = {{(32-plfb_pkg::PWM_B_W){1'b0}}, pwm_bits_r};
      plfb_pkg::REG_TICK_PERIOD: prdata = {{(32-plfb_pkg::TICK_W){1'b0}}, tick_r};
      plfb_pkg::REG_ACTIVE:      prdata = {{(32-CNT_W){1'b0}}, active_r};
      default:                   prdata = '0;
    endcase
  end

  // Control and item registers.
  plfb_pkg::state_t state_r, state_nxt;

  logic                       in_acc;
  logic [CH_W-1:0]            ch_r;
  logic [plfb_pkg::PCT_W-1:0] inten_r;
  logic [TIME_W-1:0]          ftime_r;
  logic [CNT_W-1:0]           n_r;
  logic [CNT_W-1:0]           n_in;
  logic [CH_W-1:0]            idx_r;
  logic [DUTY_W-1:0]          tgt_r;
  logic [CHANNELS_LOCAL-1:0]  valid_r;
  logic                       rd_valid_r;

  assign in_acc = in_tvalid && in_tready;
  assign n_in   = (active_r > CNT_W'(plfb_pkg::CHANNELS)) ? CNT_W'(plfb_pkg::CHANNELS)
                                                          : active_r;

  // Channel memory: step, target and current duty per channel.
  logic              ram_we;
  logic [CH_W-1:0]   ram_raddr;
  logic [MEM_W-1:0]  ram_wdata;
  logic [MEM_W-1:0]  ram_rdata;
  logic [MEM_W-1:0]  ent;

  assign ram_raddr = (state_r == plfb_pkg::ST_TICK_RD || state_r == plfb_pkg::ST_TICK_UPD)
                     ? idx_r : ch_r;

  plfb_ram #(.WIDTH(MEM_W), .DEPTH(plfb_pkg::CHANNELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_raddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent = rd_valid_r ? ram_rdata : '0;

  logic        [DUTY_W-1:0] e_cur;
  logic        [DUTY_W-1:0] e_tgt;
  logic signed [STEP_W-1:0] e_step;

  assign e_cur  = ent[DUTY_W-1:0];
  assign e_tgt  = ent[2*DUTY_W-1:DUTY_W];
  assign e_step = $signed(ent[MEM_W-1:2*DUTY_W]);

  // Divider shared by both passes of a set.
  logic              div_start;
  logic [TIME_W-1:0] div_a;
  logic [TIME_W-1:0] div_b;
  logic              div_busy;
  logic              div_done;
  logic [TIME_W-1:0] div_q;

  plfb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // Set arithmetic.
  logic [DUTY_W-1:0]        range_v;
  logic [DUTY_W:0]          tgt_prod;
  logic [plfb_pkg::TICK_W-1:0] per;
  logic signed [STEP_W-1:0] diff;
  logic [STEP_W-1:0]        diff_mag;
  logic [TIME_W-1:0]        steps;
  logic [STEP_W-1:0]        step_mag;
  logic signed [STEP_W-1:0] new_step;

  assign range_v  = plfb_pkg::duty_full_scale(pwm_bits_r);
  assign tgt_prod = (DUTY_W+1)'(plfb_pkg::pct_unit(pwm_bits_r) * inten_r);
  assign per      = (tick_r == '0) ? plfb_pkg::TICK_W'(1) : tick_r;
  assign diff     = $signed({1'b0, tgt_r}) - $signed({1'b0, e_cur});
  assign diff_mag = diff[STEP_W-1] ? STEP_W'(-diff) : STEP_W'(diff);
  assign steps    = (div_q == '0) ? TIME_W'(1) : div_q;
  assign step_mag = (div_q == '0 && diff != '0) ? STEP_W'(1) : {1'b0, div_q};
  assign new_step = diff[STEP_W-1] ? $signed(-step_mag) : $signed(step_mag);

  // Tick arithmetic.
  logic signed [STEP_W-1:0] t_d;
  logic [STEP_W-1:0]        t_dmag;
  logic [STEP_W-1:0]        t_smag;
  logic signed [STEP_W:0]   t_sum;
  logic [DUTY_W-1:0]        t_new;

  always_comb begin
    t_d    = $signed({1'b0, e_tgt}) - $signed({1'b0, e_cur});
    t_dmag = t_d[STEP_W-1] ? STEP_W'(-t_d) : STEP_W'(t_d);
    t_smag = e_step[STEP_W-1] ? STEP_W'(-e_step) : STEP_W'(e_step);
    t_sum  = $signed({2'b00, e_cur}) + $signed({e_step[STEP_W-1], e_step});
    if (t_dmag <= t_smag) begin
      t_new = e_tgt;
    end else if (t_sum[STEP_W]) begin
      t_new = '0;
    end else if (t_sum[STEP_W-1]) begin
      t_new = '1;
    end else begin
      t_new = t_sum[DUTY_W-1:0];
    end
  end

  // Result register.
  logic              slot_free;
  logic              emit_vld;
  logic [1:0]        emit_status;
  logic [CH_W-1:0]   emit_ch;
  logic [DUTY_W-1:0] emit_duty;
  logic              emit_last;
  logic              emit_go;
  logic              tick_last;

  assign slot_free = !out_tvalid || out_tready;
  assign emit_go   = emit_vld && slot_free;
  assign tick_last = ({1'b0, idx_r} + CNT_W'(1)) == n_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plfb_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == plfb_pkg::OP_TICK) begin
            if (n_in != '0) begin
              state_nxt = plfb_pkg::ST_TICK_RD;
            end
          end else if (in_tdata[9:3] > plfb_pkg::PCT_W'(plfb_pkg::PCT_MAX)) begin
            state_nxt = plfb_pkg::ST_REJ;
          end else begin
            state_nxt = plfb_pkg::ST_SET_RD;
          end
        end
      end
      plfb_pkg::ST_REJ: begin
        if (slot_free) begin
          state_nxt = plfb_pkg::ST_IDLE;
        end
      end
      plfb_pkg::ST_SET_RD:    state_nxt = plfb_pkg::ST_DIV_STEPS;
      plfb_pkg::ST_DIV_STEPS: begin
        if (div_done) begin
          state_nxt = plfb_pkg::ST_DIV_STEP;
        end
      end
      plfb_pkg::ST_DIV_STEP: begin
        if (div_done) begin
          state_nxt = plfb_pkg::ST_SET_WR;
        end
      end
      plfb_pkg::ST_SET_WR: begin
        if (slot_free) begin
          state_nxt = plfb_pkg::ST_IDLE;
        end
      end
      plfb_pkg::ST_TICK_RD:   state_nxt = plfb_pkg::ST_TICK_UPD;
      plfb_pkg::ST_TICK_UPD: begin
        if (slot_free) begin
          state_nxt = tick_last ? plfb_pkg::ST_IDLE : plfb_pkg::ST_TICK_RD;
        end
      end
      default: state_nxt = plfb_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready   = 1'b0;
    div_start   = 1'b0;
    div_a       = ftime_r;
    div_b       = TIME_W'(per);
    ram_we      = 1'b0;
    ram_wdata   = {e_step, e_tgt, t_new};
    emit_vld    = 1'b0;
    emit_status = plfb_pkg::STATUS_DUTY;
    emit_ch     = idx_r;
    emit_duty   = t_new;
    emit_last   = tick_last;
    case (state_r)
      plfb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      plfb_pkg::ST_REJ: begin
        emit_vld    = 1'b1;
        emit_status = plfb_pkg::STATUS_SET_REJ;
        emit_ch     = ch_r;
        emit_duty   = '0;
        emit_last   = 1'b1;
      end
      plfb_pkg::ST_SET_RD: begin
        div_start = 1'b1;
      end
      plfb_pkg::ST_DIV_STEPS: begin
        div_start = div_done;
        div_a     = diff_mag[TIME_W-1:0];
        div_b     = steps;
      end
      plfb_pkg::ST_SET_WR: begin
        ram_we      = slot_free;
        ram_wdata   = {new_step, tgt_r, e_cur};
        emit_vld    = 1'b1;
        emit_status = plfb_pkg::STATUS_SET_OK;
        emit_ch     = ch_r;
        emit_duty   = tgt_r;
        emit_last   = 1'b1;
      end
      plfb_pkg::ST_TICK_UPD: begin
        ram_we   = slot_free;
        emit_vld = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= plfb_pkg::ST_IDLE;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      idx_r      <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= valid_r[ram_raddr];
      if (ram_we) begin
        valid_r[ram_raddr] <= 1'b1;
      end
      if (in_acc) begin
        idx_r <= '0;
      end else if (state_r == plfb_pkg::ST_TICK_UPD && slot_free) begin
        idx_r <= idx_r + CH_W'(1);
      end
      if (emit_go) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r    <= in_tdata[2:0];
      inten_r <= in_tdata[9:3];
      ftime_r <= in_tdata[25:10];
      n_r     <= n_in;
    end
    if (state_r == plfb_pkg::ST_SET_RD) begin
      tgt_r <= (tgt_prod > {1'b0, range_v}) ? range_v : tgt_prod[DUTY_W-1:0];
    end
    if (emit_go) begin
      out_tdata <= {5'b0, emit_duty, emit_ch};
      out_tuser <= emit_status;
      out_tlast <= emit_last;
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == plfb_pkg::ST_SET_WR || state_r == plfb_pkg::ST_TICK_UPD))
    else $error("memory written outside a write-back state");

  a_tick_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plfb_pkg::ST_TICK_UPD) |-> ({1'b0, idx_r} < n_r))
    else $error("tick walked past the active channels");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plfb_pkg::ST_SET_WR && new_step == '0) |-> (diff == '0))
    else $error("zero step stored for a nonzero distance");

  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == plfb_pkg::ST_TICK_UPD && emit_go && tick_last)
      |=> (state_r == plfb_pkg::ST_IDLE))
    else $error("tick did not finish after its last word");

endmodule
`default_nettype wire

FILE: src/plfb_ram.sv
`default_nettype none
module plfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/plfb_div.sv
`default_nettype none
module plfb_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [plfb_pkg::TIME_W-1:0]  dividend,
  input  wire logic [plfb_pkg::TIME_W-1:0]  divisor,
  output logic                              busy,
  output logic                              done,
  output logic      [plfb_pkg::TIME_W-1:0]  quotient
);

  localparam int W   = plfb_pkg::TIME_W;
  localparam int C_W = $clog2(W);

  logic           busy_r;
  logic           done_r;
  logic [C_W-1:0] cnt_r;
  logic [W-1:0]   rem_r;
  logic [W-1:0]   quo_r;
  logic [W-1:0]   dvs_r;
  logic [W:0]     shifted;
  logic [W:0]     trial;
  logic [W-1:0]   rem_nxt;
  logic [W-1:0]   quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[W]) begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + C_W'(1);
        if (cnt_r == C_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: tb/plfb_fade_checker.sv
module plfb_fade_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import plfb_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [CH_W-1:0]   chan;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } duty_word_t;

  logic [PWM_B_W-1:0]       width_cfg;
  logic [TICK_W-1:0]        period_cfg;
  logic [CNT_W-1:0]         active_cfg;
  logic [DUTY_W-1:0]        cur_duty [CHANNELS];
  logic [DUTY_W-1:0]        tgt_duty [CHANNELS];
  logic signed [STEP_W-1:0] step_due [CHANNELS];
  duty_word_t               duty_words_due [$];

  initial begin
    fail_count = 0;
    pending = 0;
    words_checked = 0;
  end

  task automatic apply_fade_word(input logic op, input logic [CH_W-1:0] ch,
                                 input logic [PCT_W-1:0] pct,
                                 input logic [TIME_W-1:0] ftime);
    int b;
    int full_scale;
    int tgt;
    int per;
    int steps;
    int diff;
    int stp;
    int walk;
    int cur;
    int gap;
    int reach;
    if (op == OP_SET) begin
      if (int'(pct) > PCT_MAX) begin
        duty_words_due.push_back('{STATUS_SET_REJ, ch, '0, 1'b1});
      end else begin
        b = int'(width_cfg);
        if (b < 1) begin
          b = 1;
        end
        if (b > DUTY_W) begin
          b = DUTY_W;
        end
        full_scale = (1 << b) - 1;
        tgt = (full_scale / PCT_MAX) * int'(pct);
        if (tgt > full_scale) begin
          tgt = full_scale;
        end
        per = (period_cfg == '0) ? 1 : int'(period_cfg);
        steps = int'(ftime) / per;
        if (steps == 0) begin
          steps = 1;
        end
        diff = tgt - int'(cur_duty[ch]);
        stp = diff / steps;
        if (stp == 0 && diff != 0) begin
          stp = (diff > 0) ? 1 : -1;
        end
        tgt_duty[ch] = tgt[DUTY_W-1:0];
        step_due[ch] = stp[STEP_W-1:0];
        duty_words_due.push_back('{STATUS_SET_OK, ch, tgt[DUTY_W-1:0], 1'b1});
      end
    end else begin
      walk = (int'(active_cfg) > CHANNELS) ? CHANNELS : int'(active_cfg);
      for (int i = 0; i < walk; i++) begin
        cur = int'(cur_duty[i]);
        tgt = int'(tgt_duty[i]);
        stp = int'(step_due[i]);
        gap = (tgt - cur < 0) ? cur - tgt : tgt - cur;
        reach = (stp < 0) ? -stp : stp;
        if (gap <= reach) begin
          cur = tgt;
        end else begin
          cur = cur + stp;
          if (cur < 0) begin
            cur = 0;
          end
          if (cur > 65535) begin
            cur = 65535;
          end
        end
        cur_duty[i] = cur[DUTY_W-1:0];
        duty_words_due.push_back('{STATUS_DUTY, CH_W'(i), cur[DUTY_W-1:0],
                                   (i + 1 == walk)});
      end
    end
  endtask

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    duty_word_t w;
    if (!rst_n) begin
      width_cfg = PWM_B_W'(8);
      period_cfg = TICK_W'(1);
      active_cfg = CNT_W'(8);
      for (int i = 0; i < CHANNELS; i++) begin
        cur_duty[i] = '0;
        tgt_duty[i] = '0;
        step_due[i] = '0;
      end
      duty_words_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PWM_WIDTH: begin
            width_cfg = pwdata[PWM_B_W-1:0];
          end
          REG_TICK_PERIOD: begin
            period_cfg = pwdata[TICK_W-1:0];
          end
          REG_ACTIVE: begin
            active_cfg = pwdata[CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        apply_fade_word(in_tuser[0], in_tdata[2:0], in_tdata[9:3], in_tdata[25:10]);
      end
      if (out_tvalid && out_tready) begin
        if (duty_words_due.size() == 0) begin
          $error("unexpected result word: status %0d channel %0d duty %0d last %0d",
                 out_tuser, out_tdata[2:0], out_tdata[18:3], out_tlast);
          fail_count++;
        end else begin
          w = duty_words_due.pop_front();
          compare_field("status", w.status, out_tuser);
          compare_field("out_channel", w.chan, out_tdata[2:0]);
          compare_field("duty", w.duty, out_tdata[18:3]);
          compare_field("last", w.last, out_tlast);
          words_checked++;
        end
      end
    end
    pending = duty_words_due.size();
  end

endmodule

FILE: tb/tb_pwm_led_fade_bank_unit.sv
module tb_pwm_led_fade_bank_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import plfb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int BLOCK_WORDS  = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int fail_count;
  int pending;
  int words_checked;

  pwm_led_fade_bank_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  plfb_fade_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
  );

  initial begin
    forever begin
      #2 clk = ~clk;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d result words outstanding.",
               cycle_count, pending);
      $display("tb_pwm_led_fade_bank_unit: FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(input logic op, input logic [CH_W-1:0] ch,
                           input logic [PCT_W-1:0] pct, input logic [TIME_W-1:0] ftime);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'b0, ftime, pct, ch};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic set_word(input logic [CH_W-1:0] ch, input logic [PCT_W-1:0] pct,
                          input logic [TIME_W-1:0] ftime);
    send_word(OP_SET, ch, pct, ftime);
  endtask

  // Channel, percent and time carry random junk on a tick; the block must ignore them.
  task automatic tick_word();
    send_word(OP_TICK, CH_W'($urandom), PCT_W'($urandom), TIME_W'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input int width, input int period, input int active);
    drain();
    reg_write(REG_PWM_WIDTH, width);
    reg_write(REG_TICK_PERIOD, period);
    reg_write(REG_ACTIVE, active);
  endtask

  task automatic configure_random(output int period_set);
    int width;
    int period;
    int active;
    width = ($urandom_range(99) < 70) ? $urandom_range(16, 7) : $urandom_range(31);
    case ($urandom_range(4))
      0: period = ($urandom_range(1) != 0) ? 0 : 1023;
      1: period = $urandom_range(1000, 1);
      default: period = $urandom_range(50, 1);
    endcase
    if ($urandom_range(99) < 15) begin
      active = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 9);
    end else begin
      active = $urandom_range(8, 1);
    end
    configure(width, period, active);
    period_set = period;
  endtask

  // Mostly ticks; sets are mostly valid, with fade times up to 3 or 40 tick periods or the full range.
  task automatic random_word(input int period);
    int per;
    int span;
    int ftime;
    int pct;
    per = (period == 0) ? 1 : period;
    if ($urandom_range(99) < 35) begin
      pct = ($urandom_range(99) < 10) ? $urandom_range(127, 101) : $urandom_range(100);
      case ($urandom_range(3))
        0: span = 3 * per;
        1: span = 40 * per;
        default: span = 65535;
      endcase
      if (span > 65535) begin
        span = 65535;
      end
      ftime = ($urandom_range(9) == 0) ? (($urandom_range(1) != 0) ? 65535 : 0)
                                       : $urandom_range(span);
      set_word(CH_W'($urandom_range(7)), PCT_W'(pct), TIME_W'(ftime));
    end else begin
      tick_word();
    end
  endtask

  initial begin
    int period_now;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 37;
    recv_idle_pct = 88;

    set_word(3'd0, 7'd100, 16'd0);
    set_word(3'd7, 7'd127, 16'hFFFF);
    set_word(3'd1, 7'd101, 16'd5);
    set_word(3'd3, 7'd50, 16'hFFFF);
    set_word(3'd2, 7'd0, 16'd10);
    set_word(3'd4, 7'd37, 16'd4);
    tick_word();
    tick_word();
    configure(16, 1000, 3);
    set_word(3'd5, 7'd100, 16'hFFFF);
    set_word(3'd1, 7'd100, 16'd2500);
    set_word(3'd0, 7'd0, 16'd3000);
    tick_word();
    tick_word();
    tick_word();
    tick_word();
    configure(0, 0, 15);
    set_word(3'd6, 7'd100, 16'd1);
    tick_word();
    configure(31, 1023, 0);
    set_word(3'd7, 7'd100, 16'd0);
    tick_word();
    tick_word();
    configure(6, 1, 8);
    set_word(3'd5, 7'd100, 16'd100);
    tick_word();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        configure_random(period_now);
        for (int k = 0; k < BLOCK_WORDS; k++) begin
          random_word(period_now);
        end
      end
    end

    drain();
    $display("Sent %0d input words and checked %0d result words across", words_sent,
             words_checked);
    $display("directed corners, random register settings and three flow-control mixes.");
    if (fail_count == 0) begin
      $display("tb_pwm_led_fade_bank_unit: PASS");
    end else begin
      $display("tb_pwm_led_fade_bank_unit: FAIL");
    end
    $finish;
  end

endmodule
